### src/psp_pkg.sv
// shared types and constants for the point sort and path length block
package psp_pkg;

    localparam int COORD_W = 16;
    localparam int PATH_W = 24;
    localparam int SHORT_W = 16;
    localparam int SQ_W = 34;
    localparam int ROOT_W = 17;
    localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};
    localparam logic [SHORT_W-1:0] SHORT_MAX = {SHORT_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] sorted_x;
        logic signed [COORD_W-1:0] sorted_y;
        logic [PATH_W-1:0]         path_length;
        logic [SHORT_W-1:0]        shortcut_length;
        logic                      overflow_flag;
        logic                      last_out;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic              valid;
        logic [SQ_W-1:0]   key;
        point_t            pt;
    } cell_data_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

### src/psp_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module psp_sqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [psp_pkg::SQ_W-1:0]      radicand,
    output logic                          done,
    output logic [psp_pkg::ROOT_W-1:0]    root
);

    localparam int STEPS = psp_pkg::SQ_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [psp_pkg::SQ_W-1:0]   rem_reg, rem_next;
    logic [psp_pkg::SQ_W-1:0]   res_reg, res_next;
    logic [psp_pkg::SQ_W-1:0]   bit_reg, bit_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [psp_pkg::SQ_W-1:0]   trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = radicand;
            res_next = '0;
            bit_next = {2'b01, {(psp_pkg::SQ_W-2){1'b0}}};
            cnt_next = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[psp_pkg::ROOT_W-1:0];

endmodule

### src/psp_cell.sv
// one sort cell: holds a point and its key, keeps the chain in order
module psp_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  psp_pkg::cell_ctrl_t   ctrl,
    input  psp_pkg::cell_data_t   new_item,
    input  psp_pkg::cell_data_t   prev_item,
    input  logic                  prev_takes,
    input  psp_pkg::cell_data_t   next_item,
    output psp_pkg::cell_data_t   item,
    output logic                  takes
);

    psp_pkg::cell_data_t data_reg, data_next;

    // new point lands here or earlier: cell empty or stored key strictly greater
    assign takes = !data_reg.valid || (data_reg.key > new_item.key);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_out)
        begin
            data_next = next_item;
        end
        else if (ctrl.insert)
        begin
            if (prev_takes)
                data_next = prev_item;
            else if (takes)
                data_next = new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign item = data_reg;

endmodule

### src/point_sort_and_path_length.sv
// top level: point loading, path and shortcut length and sorted emission
//
// usage: present a point on in_item and raise start while busy is low; the
// transfer happens at that edge. mark the final point with last_in.
// each point is inserted at once into a chain of MAX_POINTS sort cells, so
// ordering costs no extra time. each point after the first needs a segment
// length from the shared square root unit; busy stays high until that root
// is done. on the final point of a list of two or more, the shortcut root
// runs as well, after a setup state that selects its operands; then the chain
// shifts toward cell 0 and one sorted point leaves per cycle on result with
// result_valid high; last_out marks the final one.
// points past capacity are dropped and flagged.
// the receiver cannot stall: each result is taken in the cycle it shows.
// reset clears the chain, counters and sums; the next list may start as
// soon as busy falls, which it does as the last result shows.
module point_sort_and_path_length
#(
    parameter int MAX_POINTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  psp_pkg::in_item_t     in_item,
    output logic                  busy,
    output logic                  result_valid,
    output psp_pkg::out_item_t    result
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_SHORT_GO,
        ST_SHORT,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            emit_reg;
    psp_pkg::point_t             first_reg, prev_reg;
    logic [psp_pkg::PATH_W-1:0]  path_reg;
    logic [psp_pkg::SHORT_W-1:0] short_reg;
    logic                        drop_reg;
    logic                        last_reg;
    logic                        valid_reg;
    psp_pkg::out_item_t          result_reg;

    psp_pkg::point_t             p;
    logic                        accept;
    logic signed [16:0]          dx, dy;
    logic [psp_pkg::SQ_W-1:0]    sq;
    psp_pkg::point_t             da, db;
    logic                        sq_start;
    logic                        sq_done;
    logic [psp_pkg::ROOT_W-1:0]  root;
    logic [psp_pkg::PATH_W:0]    path_sum;
    logic signed [33:0]          kx, ky;
    logic [psp_pkg::SQ_W-1:0]    key;

    psp_pkg::cell_ctrl_t         ctrl;
    psp_pkg::cell_data_t         new_item;
    psp_pkg::cell_data_t         items [MAX_POINTS+1];
    logic                        takes [MAX_POINTS+1];

    assign accept = start && (state_reg == ST_IDLE);
    assign p.x = in_item.x_coord;
    assign p.y = in_item.y_coord;

    // segment or shortcut operands
    always_comb
    begin
        if (state_reg == ST_SHORT_GO)
        begin
            da = first_reg;
            db = prev_reg;
        end
        else
        begin
            da = p;
            db = prev_reg;
        end
    end

    assign dx = 17'(da.x) - 17'(db.x);
    assign dy = 17'(da.y) - 17'(db.y);
    assign sq = psp_pkg::SQ_W'(34'(dx * dx) + 34'(dy * dy));
    assign sq_start = (accept && count_reg != '0) || (state_reg == ST_SHORT_GO);

    psp_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq),
        .done     (sq_done),
        .root     (root)
    );

    assign kx = 34'(p.x * p.x);
    assign ky = 34'(p.y * p.y);
    assign key = psp_pkg::SQ_W'(kx) + psp_pkg::SQ_W'(ky);

    assign new_item.valid = 1'b1;
    assign new_item.key = key;
    assign new_item.pt = p;

    assign ctrl.insert = accept && (count_reg < CNT_W'(MAX_POINTS));
    assign ctrl.shift_out = (state_reg == ST_EMIT);

    assign items[MAX_POINTS] = '0;
    assign takes[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++)
        begin : g_cell
            psp_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_item   (new_item),
                .prev_item  ((g == 0) ? new_item : items[(g == 0) ? 0 : g-1]),
                .prev_takes (takes[g]),
                .next_item  (items[g+1]),
                .item       (items[g]),
                .takes      (takes[g+1])
            );
        end
    endgenerate

    assign path_sum = {1'b0, path_reg} + (psp_pkg::PATH_W+1)'(root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            emit_reg <= '0;
            first_reg <= '0;
            prev_reg <= '0;
            path_reg <= '0;
            short_reg <= '0;
            drop_reg <= 1'b0;
            last_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        prev_reg <= p;
                        last_reg <= in_item.last_in;
                        if (count_reg == '0)
                        begin
                            first_reg <= p;
                            path_reg <= '0;
                            drop_reg <= 1'b0;
                        end
                        if (count_reg < CNT_W'(MAX_POINTS))
                            count_reg <= count_reg + 1'b1;
                        else
                            drop_reg <= 1'b1;
                        if (count_reg != '0)
                            state_reg <= ST_SEG;
                        else if (in_item.last_in)
                        begin
                            short_reg <= '0;
                            emit_reg <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_SEG:
                begin
                    if (sq_done)
                    begin
                        path_reg <= path_sum[psp_pkg::PATH_W]
                            ? psp_pkg::PATH_MAX : path_sum[psp_pkg::PATH_W-1:0];
                        state_reg <= last_reg ? ST_SHORT_GO : ST_IDLE;
                    end
                end
                ST_SHORT_GO:
                begin
                    state_reg <= ST_SHORT;
                end
                ST_SHORT:
                begin
                    if (sq_done)
                    begin
                        short_reg <= root[psp_pkg::ROOT_W-1] ? psp_pkg::SHORT_MAX
                            : root[psp_pkg::SHORT_W-1:0];
                        emit_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    valid_reg <= 1'b1;
                    result_reg.sorted_x <= items[0].pt.x;
                    result_reg.sorted_y <= items[0].pt.y;
                    result_reg.path_length <= path_reg;
                    result_reg.shortcut_length <= short_reg;
                    result_reg.overflow_flag <= drop_reg;
                    result_reg.last_out <= (emit_reg + 1'b1 == count_reg);
                    emit_reg <= emit_reg + 1'b1;
                    if (emit_reg + 1'b1 == count_reg)
                    begin
                        count_reg <= '0;
                        path_reg <= '0;
                        drop_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign result = result_reg;

endmodule

### test/tb.sv
// testbench for point_sort_and_path_length: directed table then random lists, checked by predictor
`timescale 1ns / 100ps

module tb;

    localparam int NPTS = 16;
    localparam int LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic start;
    psp_pkg::in_item_t in_item;
    logic busy;
    logic result_valid;
    psp_pkg::out_item_t result;

    point_sort_and_path_length #(.MAX_POINTS(NPTS)) DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .in_item(in_item),
        .busy(busy),
        .result_valid(result_valid),
        .result(result)
    );

    typedef struct {
        psp_pkg::in_item_t item;
        logic has_exp;
        psp_pkg::out_item_t exp;
    } row_t;

    psp_pkg::point_t list_pts[NPTS];
    int list_cnt;
    psp_pkg::point_t first_pt;
    psp_pkg::point_t prev_pt;
    logic [psp_pkg::PATH_W-1:0] path_sum;
    logic dropped;
    psp_pkg::out_item_t sorted_q[$];
    psp_pkg::out_item_t typed_q[$];
    int err_cnt = 0;
    int cycle_cnt = 0;
    int idle_pct;
    row_t rows[$];

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic [33:0] sq_sum(psp_pkg::point_t a, psp_pkg::point_t b);
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        dx = 18'(a.x) - 18'(b.x);
        dy = 18'(a.y) - 18'(b.y);
        return 34'(dx * dx) + 34'(dy * dy);
    endfunction

    function automatic logic [16:0] floor_root(logic [33:0] v);
        logic [16:0] r;
        r = 0;
        for (int b = 16; b >= 0; b--)
        begin
            if (35'(r | (17'd1 << b)) * 35'(r | (17'd1 << b)) <= 70'(v))
                r = r | (17'd1 << b);
        end
        return r;
    endfunction

    task automatic predict_point(psp_pkg::in_item_t it);
        psp_pkg::point_t p;
        psp_pkg::point_t ord[NPTS];
        logic [33:0] keys[NPTS];
        logic [33:0] kq;
        logic [24:0] s;
        logic [16:0] sc;
        psp_pkg::out_item_t o;
        int j;
        p.x = it.x_coord;
        p.y = it.y_coord;
        if (list_cnt == 0)
        begin
            first_pt = p;
            path_sum = 0;
            dropped = 1'b0;
        end
        else
        begin
            s = 25'(path_sum) + 25'(floor_root(sq_sum(p, prev_pt)));
            path_sum = (s > 25'(psp_pkg::PATH_MAX)) ? psp_pkg::PATH_MAX
                : s[psp_pkg::PATH_W-1:0];
        end
        prev_pt = p;
        if (list_cnt < NPTS)
        begin
            list_pts[list_cnt] = p;
            list_cnt++;
        end
        else
            dropped = 1'b1;
        if (!it.last_in)
            return;
        sc = floor_root(sq_sum(first_pt, p));
        if (sc > 17'(psp_pkg::SHORT_MAX))
            sc = 17'(psp_pkg::SHORT_MAX);
        for (int i = 0; i < list_cnt; i++)
        begin
            kq = sq_sum(list_pts[i], '0);
            j = i;
            while (j > 0 && keys[j-1] > kq)
            begin
                keys[j] = keys[j-1];
                ord[j] = ord[j-1];
                j--;
            end
            keys[j] = kq;
            ord[j] = list_pts[i];
        end
        for (int k = 0; k < list_cnt; k++)
        begin
            o.sorted_x = ord[k].x;
            o.sorted_y = ord[k].y;
            o.path_length = path_sum;
            o.shortcut_length = sc[psp_pkg::SHORT_W-1:0];
            o.overflow_flag = dropped;
            o.last_out = (k == list_cnt - 1);
            sorted_q.push_back(o);
        end
        list_cnt = 0;
        path_sum = 0;
        dropped = 1'b0;
    endtask

    task automatic send_point(psp_pkg::in_item_t it);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_point(it);
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic psp_pkg::in_item_t mk(int x, int y, bit lst);
        psp_pkg::in_item_t it;
        it.x_coord = 16'(x);
        it.y_coord = 16'(y);
        it.last_in = lst;
        return it;
    endfunction

    function automatic psp_pkg::out_item_t mko(int x, int y, int pl, int sc, bit ov, bit lo);
        psp_pkg::out_item_t o;
        o.sorted_x = 16'(x);
        o.sorted_y = 16'(y);
        o.path_length = 24'(pl);
        o.shortcut_length = 16'(sc);
        o.overflow_flag = ov;
        o.last_out = lo;
        return o;
    endfunction

    task automatic add_row(psp_pkg::in_item_t it, bit he, psp_pkg::out_item_t e);
        row_t r;
        r.item = it;
        r.has_exp = he;
        r.exp = e;
        rows.push_back(r);
    endtask

    always @(posedge clk)
    begin
        psp_pkg::out_item_t e;
        if (rst_n && result_valid)
        begin
            if (sorted_q.size() == 0)
            begin
                $error("result with nothing expected");
                err_cnt++;
            end
            else
            begin
                e = sorted_q.pop_front();
                if (typed_q.size() > 0)
                    e = typed_q.pop_front();
                if (result.sorted_x !== e.sorted_x)
                begin
                    $error("sorted_x exp %0d got %0d", e.sorted_x, result.sorted_x);
                    err_cnt++;
                end
                if (result.sorted_y !== e.sorted_y)
                begin
                    $error("sorted_y exp %0d got %0d", e.sorted_y, result.sorted_y);
                    err_cnt++;
                end
                if (result.path_length !== e.path_length)
                begin
                    $error("path_length exp %0d got %0d", e.path_length, result.path_length);
                    err_cnt++;
                end
                if (result.shortcut_length !== e.shortcut_length)
                begin
                    $error("shortcut_length exp %0d got %0d", e.shortcut_length,
                        result.shortcut_length);
                    err_cnt++;
                end
                if (result.overflow_flag !== e.overflow_flag)
                begin
                    $error("overflow_flag exp %0d got %0d", e.overflow_flag,
                        result.overflow_flag);
                    err_cnt++;
                end
                if (result.last_out !== e.last_out)
                begin
                    $error("last_out exp %0d got %0d", e.last_out, result.last_out);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int n;
        int sent;
        int big;
        psp_pkg::out_item_t none;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        idle_pct = 0;
        list_cnt = 0;
        path_sum = 0;
        dropped = 1'b0;
        first_pt = '0;
        prev_pt = '0;
        none = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single point lists at the extremes
        add_row(mk(0, 0, 1), 1, mko(0, 0, 0, 0, 0, 1));
        add_row(mk(-32768, 32767, 1), 1, mko(-32768, 32767, 0, 0, 0, 1));
        add_row(mk(32767, -32768, 1), 1, mko(32767, -32768, 0, 0, 0, 1));
        // 3-4-5 segment, sorted nearest first
        add_row(mk(30, 40, 0), 0, none);
        add_row(mk(0, 0, 1), 1, mko(0, 0, 50, 50, 0, 0));
        // opposite corners: shortcut saturates
        add_row(mk(-32768, -32768, 0), 0, none);
        add_row(mk(32767, 32767, 1), 0, none);
        // equal keys keep input order
        add_row(mk(5, 0, 0), 0, none);
        add_row(mk(0, -5, 0), 0, none);
        add_row(mk(-5, 0, 0), 0, none);
        add_row(mk(3, 4, 1), 0, none);
        // more points than capacity
        for (int i = 0; i < 19; i++)
            add_row(mk(100 - i * 7, i * 3 - 20, i == 18), 0, none);
        foreach (rows[i])
        begin
            if (rows[i].has_exp)
                typed_q.push_back(rows[i].exp);
            send_point(rows[i].item);
        end
        // only the first result of the 3-4-5 list was typed; clear any typed rows left
        typed_q.delete();
        while (sorted_q.size() > 0)
            @(posedge clk);

        sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 70 : (ph == 2) ? 0 : 12;
            while (sent < (ph + 1) * 110)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
                big = $urandom_range(3);
                for (int i = 0; i < n; i++)
                begin
                    if (big == 0)
                        send_point(mk($urandom, $urandom, i == n - 1));
                    else
                        send_point(mk($signed($urandom_range(400)) - 200,
                            $signed($urandom_range(400)) - 200, i == n - 1));
                    sent++;
                end
            end
        end

        while (sorted_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
